@@ sv/stomp_frame_parser_top_assert.svh @@
`ifndef STOMP_FRAME_PARSER_TOP_ASSERT_SVH
`define STOMP_FRAME_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, held off while rst_n is low.
`define STFP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, held off while rst_n is low.
`define STFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/stfp_pkg.sv @@
package stfp_pkg;

    typedef enum logic [2:0] {
        PH_CMD,
        PH_KEY,
        PH_VAL,
        PH_BODY_LEN,
        PH_BODY_NUL,
        PH_ERR
    } phase_t;

    typedef enum logic [3:0] {
        ERR_NONE          = 4'd0,
        ERR_EOF_CMD       = 4'd1,
        ERR_EOF_HDR       = 4'd2,
        ERR_MISSING_COLON = 4'd3,
        ERR_DANGLING_ESC  = 4'd4,
        ERR_UNKNOWN_ESC   = 4'd5,
        ERR_BAD_LENGTH    = 4'd6,
        ERR_MISSING_DATA  = 4'd7,
        ERR_MISSING_NUL   = 4'd8
    } err_code_t;

    typedef enum logic [1:0] {
        KIND_CMD,
        KIND_KEY,
        KIND_VAL,
        KIND_BODY
    } field_kind_t;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_C      = 8'h63;

    // length of "content-length"
    localparam logic [3:0] KEY_LEN = 4'd14;

    typedef struct packed {
        logic       ok;
        logic [7:0] ch;
    } unesc_t;

    // One result of the parser, plus a flag for whether the byte yields one.
    typedef struct packed {
        logic        has_result;
        logic [7:0]  out_byte;
        logic        byte_valid;
        field_kind_t field_kind;
        logic        field_end;
        logic        length_header;
        logic        frame_end;
        err_code_t   error_code;
    } result_t;

    function automatic logic [7:0] key_char(input logic [3:0] pos);
        logic [7:0] ch;
        case (pos)
            4'd0:    ch = 8'h63; // c
            4'd1:    ch = 8'h6F; // o
            4'd2:    ch = 8'h6E; // n
            4'd3:    ch = 8'h74; // t
            4'd4:    ch = 8'h65; // e
            4'd5:    ch = 8'h6E; // n
            4'd6:    ch = 8'h74; // t
            4'd7:    ch = 8'h2D; // -
            4'd8:    ch = 8'h6C; // l
            4'd9:    ch = 8'h65; // e
            4'd10:   ch = 8'h6E; // n
            4'd11:   ch = 8'h67; // g
            4'd12:   ch = 8'h74; // t
            4'd13:   ch = 8'h68; // h
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic unesc_t unescape(input logic [7:0] c);
        unesc_t r;
        r.ok = 1'b1;
        case (c)
            CH_N:      r.ch = CH_LF;
            CH_R:      r.ch = CH_CR;
            CH_BSLASH: r.ch = CH_BSLASH;
            CH_C:      r.ch = CH_COLON;
            default:
            begin
                r.ok = 1'b0;
                r.ch = 8'h00;
            end
        endcase
        return r;
    endfunction

endpackage

@@ sv/stfp_in_reg.sv @@
module stfp_in_reg
    import stfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_data,
    input  logic       s_eos,
    input  logic       take,
    output logic       item_valid,
    output logic [7:0] item_byte,
    output logic       item_eos
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       eos_reg;

    assign s_tready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // hold the payload until the parser takes it
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            byte_reg <= s_data;
            eos_reg  <= s_eos;
        end
    end

    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;
    assign item_eos   = eos_reg;

endmodule

@@ sv/stfp_parser.sv @@
module stfp_parser
    import stfp_pkg::*;
#(
    parameter int LENGTH_WIDTH = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic [7:0] item_byte,
    input  logic       item_eos,
    output result_t    res
);

    phase_t                  phase_reg,          phase_next;
    logic                    esc_reg,            esc_next;
    logic                    line_started_reg,   line_started_next;
    logic [3:0]              match_pos_reg,      match_pos_next;
    logic                    mismatch_reg,       mismatch_next;
    logic                    decided_reg,        decided_next;
    logic                    known_reg,          known_next;
    logic                    has_digit_reg,      has_digit_next;
    logic [LENGTH_WIDTH-1:0] accum_reg,          accum_next;
    logic [LENGTH_WIDTH-1:0] remaining_reg,      remaining_next;

    logic                    is_cl;
    logic                    parsing;
    unesc_t                  ue;
    logic [3:0]              digit;
    logic [LENGTH_WIDTH+3:0] accum_x10;

    assign is_cl   = !mismatch_reg && (match_pos_reg == KEY_LEN);
    assign parsing = is_cl && !decided_reg;
    assign ue      = unescape(item_byte);

    // low nibble of the unescaped byte, only used when it is a digit
    assign digit   = esc_reg ? ue.ch[3:0] : item_byte[3:0];

    // accum * 10 + digit, four guard bits catch overflow
    always_comb
    begin
        accum_x10 = {1'b0, accum_reg, 3'b000} + {3'b000, accum_reg, 1'b0}
                  + {{LENGTH_WIDTH{1'b0}}, digit};
    end

    always_comb
    begin
        logic       emit;
        logic [7:0] u;
        logic       dec_ok;

        res               = '0;
        phase_next        = phase_reg;
        esc_next          = esc_reg;
        line_started_next = line_started_reg;
        match_pos_next    = match_pos_reg;
        mismatch_next     = mismatch_reg;
        decided_next      = decided_reg;
        known_next        = known_reg;
        has_digit_next    = has_digit_reg;
        accum_next        = accum_reg;
        remaining_next    = remaining_reg;
        emit              = 1'b0;
        dec_ok            = 1'b1;
        u                 = item_byte;

        // shared unescape for key and value bytes
        if (esc_reg)
        begin
            u      = ue.ch;
            dec_ok = ue.ok;
        end

        if (item_eos)
        begin
            case (phase_reg)
                PH_CMD:
                begin
                    res.has_result = line_started_reg;
                    res.error_code = line_started_reg ? ERR_EOF_CMD : ERR_NONE;
                end
                PH_KEY, PH_VAL:
                begin
                    res.has_result = 1'b1;
                    res.error_code = ERR_EOF_HDR;
                end
                PH_BODY_LEN:
                begin
                    res.has_result = 1'b1;
                    res.error_code = ERR_MISSING_DATA;
                end
                PH_BODY_NUL:
                begin
                    res.has_result = 1'b1;
                    res.error_code = ERR_MISSING_NUL;
                end
                default:
                begin
                    res.has_result = 1'b0;
                end
            endcase
            emit = 1'b1;   // marks a return to reset state below
        end
        else
        begin
            case (phase_reg)
                PH_CMD:
                begin
                    res.has_result = 1'b1;
                    if (item_byte == CH_LF)
                    begin
                        phase_next        = PH_KEY;
                        line_started_next = 1'b0;
                        res.field_end     = 1'b1;
                    end
                    else
                    begin
                        line_started_next = 1'b1;
                        res.out_byte      = item_byte;
                        res.byte_valid    = 1'b1;
                    end
                end

                PH_KEY:
                begin
                    if (item_byte == CH_LF)
                    begin
                        if (line_started_reg)
                        begin
                            phase_next     = PH_ERR;
                            res.has_result = 1'b1;
                            res.error_code = ERR_MISSING_COLON;
                        end
                        else
                        begin
                            phase_next     = known_reg ? PH_BODY_LEN : PH_BODY_NUL;
                            remaining_next = accum_reg;
                        end
                    end
                    else
                    begin
                        line_started_next = 1'b1;
                        if (item_byte == CH_COLON)
                        begin
                            res.has_result = 1'b1;
                            if (esc_reg)
                            begin
                                phase_next     = PH_ERR;
                                res.error_code = ERR_DANGLING_ESC;
                            end
                            else
                            begin
                                phase_next     = PH_VAL;
                                res.field_kind = KIND_KEY;
                                res.field_end  = 1'b1;
                            end
                        end
                        else if (esc_reg && !dec_ok)
                        begin
                            phase_next     = PH_ERR;
                            res.has_result = 1'b1;
                            res.error_code = ERR_UNKNOWN_ESC;
                        end
                        else if (!esc_reg && (item_byte == CH_BSLASH))
                        begin
                            esc_next = 1'b1;
                        end
                        else
                        begin
                            esc_next       = 1'b0;
                            res.has_result = 1'b1;
                            res.out_byte   = u;
                            res.byte_valid = 1'b1;
                            res.field_kind = KIND_KEY;
                            // advance the content-length match
                            if (!mismatch_reg && (match_pos_reg < KEY_LEN)
                                && (u == key_char(match_pos_reg)))
                            begin
                                match_pos_next = 4'(match_pos_reg + 4'd1);
                            end
                            else
                            begin
                                mismatch_next = 1'b1;
                            end
                        end
                    end
                end

                PH_VAL:
                begin
                    if (item_byte == CH_LF)
                    begin
                        res.has_result = 1'b1;
                        if (esc_reg)
                        begin
                            phase_next     = PH_ERR;
                            res.error_code = ERR_DANGLING_ESC;
                        end
                        else
                        begin
                            if (is_cl)
                            begin
                                if (!decided_reg)
                                begin
                                    decided_next      = 1'b1;
                                    known_next        = has_digit_reg;
                                    res.length_header = has_digit_reg;
                                end
                                else
                                begin
                                    res.length_header = known_reg;
                                end
                            end
                            phase_next        = PH_KEY;
                            line_started_next = 1'b0;
                            match_pos_next    = 4'd0;
                            mismatch_next     = 1'b0;
                            res.field_kind    = KIND_VAL;
                            res.field_end     = 1'b1;
                        end
                    end
                    else if (esc_reg && !dec_ok)
                    begin
                        phase_next     = PH_ERR;
                        res.has_result = 1'b1;
                        res.error_code = ERR_UNKNOWN_ESC;
                    end
                    else if (!esc_reg && (item_byte == CH_BSLASH))
                    begin
                        esc_next = 1'b1;
                    end
                    else if (parsing && (!(u inside {[CH_ZERO:CH_NINE]})
                             || (|accum_x10[LENGTH_WIDTH+3:LENGTH_WIDTH])))
                    begin
                        phase_next     = PH_ERR;
                        res.has_result = 1'b1;
                        res.error_code = ERR_BAD_LENGTH;
                    end
                    else
                    begin
                        esc_next = 1'b0;
                        if (parsing)
                        begin
                            accum_next     = accum_x10[LENGTH_WIDTH-1:0];
                            has_digit_next = 1'b1;
                        end
                        res.has_result = 1'b1;
                        res.out_byte   = u;
                        res.byte_valid = 1'b1;
                        res.field_kind = KIND_VAL;
                    end
                end

                PH_BODY_LEN:
                begin
                    res.has_result = 1'b1;
                    if (remaining_reg != '0)
                    begin
                        remaining_next = LENGTH_WIDTH'(remaining_reg - 1'b1);
                        res.out_byte   = item_byte;
                        res.byte_valid = 1'b1;
                        res.field_kind = KIND_BODY;
                    end
                    else if (item_byte != CH_NUL)
                    begin
                        phase_next     = PH_ERR;
                        res.error_code = ERR_MISSING_NUL;
                    end
                    else
                    begin
                        emit           = 1'b1;
                        res.field_kind = KIND_BODY;
                        res.field_end  = 1'b1;
                        res.frame_end  = 1'b1;
                    end
                end

                PH_BODY_NUL:
                begin
                    res.has_result = 1'b1;
                    res.field_kind = KIND_BODY;
                    if (item_byte == CH_NUL)
                    begin
                        emit          = 1'b1;
                        res.field_end = 1'b1;
                        res.frame_end = 1'b1;
                    end
                    else
                    begin
                        res.out_byte   = item_byte;
                        res.byte_valid = 1'b1;
                    end
                end

                default:
                begin
                    // drop bytes until end of stream
                    res.has_result = 1'b0;
                end
            endcase
        end

        // end of stream or closing NUL: back to reset state
        if (emit)
        begin
            phase_next        = PH_CMD;
            esc_next          = 1'b0;
            line_started_next = 1'b0;
            match_pos_next    = 4'd0;
            mismatch_next     = 1'b0;
            decided_next      = 1'b0;
            known_next        = 1'b0;
            has_digit_next    = 1'b0;
            accum_next        = '0;
            remaining_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_CMD;
            esc_reg          <= 1'b0;
            line_started_reg <= 1'b0;
            match_pos_reg    <= 4'd0;
            mismatch_reg     <= 1'b0;
            decided_reg      <= 1'b0;
            known_reg        <= 1'b0;
            has_digit_reg    <= 1'b0;
            accum_reg        <= '0;
            remaining_reg    <= '0;
        end
        else if (advance)
        begin
            phase_reg        <= phase_next;
            esc_reg          <= esc_next;
            line_started_reg <= line_started_next;
            match_pos_reg    <= match_pos_next;
            mismatch_reg     <= mismatch_next;
            decided_reg      <= decided_next;
            known_reg        <= known_next;
            has_digit_reg    <= has_digit_next;
            accum_reg        <= accum_next;
            remaining_reg    <= remaining_next;
        end
    end

endmodule

@@ sv/stomp_frame_parser_top.sv @@
// Frame deframer for a STOMP-style byte stream, one byte per transfer in and at most
// one result per byte out. Bytes enter on the s_axis side (tuser set means end of stream,
// no byte present); each is held in an input register, parsed combinationally against
// the frame state, and the result lands in an output register for the m_axis side. A
// result is a command, unescaped header key/value or body byte (tuser bit 0 set), an
// end-of-field mark (tlast set; frame end and content-length flags ride on it), or an
// error code in tdata[11:8]. Backslash escapes and the empty line ending the headers
// produce no result. After an error, bytes are dropped until end of stream, which also
// returns the parser to its reset state. Throughput is one byte per clock while results
// drain; a byte with a result stalls while the output register is full and not taken.
// The rate is set by the frame state loop, whose longest path is the LENGTH_WIDTH-bit
// multiply-by-ten and add of the content-length accumulator. Both sides are decoupled:
// a new byte is taken while a finished result still waits on m_axis_tready.
`include "stomp_frame_parser_top_assert.svh"

module stomp_frame_parser_top
    import stfp_pkg::*;
#(
    parameter int LENGTH_WIDTH = 64    // content-length counter width, 16 to 64
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] end_of_stream

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [11:8] error_code, [15:12] zero
    output logic        m_axis_tlast,   // field_end
    output logic [4:0]  m_axis_tuser    // [0] byte_valid, [2:1] field_kind,
                                        // [3] length_header, [4] frame_end
);

    logic       item_valid;
    logic [7:0] item_byte;
    logic       item_eos;
    logic       advance;
    result_t    res;

    logic       out_valid_reg;
    logic       out_valid_next;
    result_t    out_res_reg;

    // Take the held byte when its result has a free output slot, or when it
    // yields nothing at all.
    assign advance = item_valid && (!out_valid_reg || m_axis_tready || !res.has_result);

    stfp_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_axis_tvalid),
        .s_tready   (s_axis_tready),
        .s_data     (s_axis_tdata),
        .s_eos      (s_axis_tuser[0]),
        .take       (advance),
        .item_valid (item_valid),
        .item_byte  (item_byte),
        .item_eos   (item_eos)
    );

    stfp_parser #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .item_byte (item_byte),
        .item_eos  (item_eos),
        .res       (res)
    );

    // Output register: load on a new result, drop once the transfer completes.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && res.has_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.has_result)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_res_reg.error_code, out_res_reg.out_byte};
    assign m_axis_tlast  = out_res_reg.field_end;
    assign m_axis_tuser  = {out_res_reg.frame_end, out_res_reg.length_header,
                            out_res_reg.field_kind, out_res_reg.byte_valid};

    // Error results carry nothing but the code.
    `STFP_ASSERT_NOW(a_err_clean, m_axis_tvalid && (m_axis_tdata[11:8] != ERR_NONE), (m_axis_tuser == 5'd0) && (m_axis_tdata[7:0] == 8'd0) && !m_axis_tlast, "error result carries extra fields")
    // A field end mark never carries a byte.
    `STFP_ASSERT_NOW(a_mark_no_byte, m_axis_tvalid && m_axis_tlast, !m_axis_tuser[0] && (m_axis_tdata[7:0] == 8'd0), "field end mark carries a byte")
    // Frame end only on the body end mark.
    `STFP_ASSERT_NOW(a_frame_end_body, m_axis_tvalid && m_axis_tuser[4], m_axis_tlast && (m_axis_tuser[2:1] == KIND_BODY), "frame end outside body end mark")
    // Content-length flag only on a value end mark.
    `STFP_ASSERT_NOW(a_len_flag_value, m_axis_tvalid && m_axis_tuser[3], m_axis_tlast && (m_axis_tuser[2:1] == KIND_VAL), "length flag outside value end mark")
    // A parsed result reaches the output register in the next cycle.
    `STFP_ASSERT_NEXT(a_result_lands, advance && res.has_result, m_axis_tvalid, "parsed result lost")

endmodule

@@ dv/stomp_frame_parser_top_test.sv @@
module stomp_frame_parser_top_test;
    import stfp_pkg::*;

    // One stream byte waiting to be offered. A pause entry carries no byte: it makes
    // the sender wait until every predicted result has come back.
    typedef struct packed {
        logic [7:0] data;
        logic       eos;
        logic       pause;
    } stream_item_t;

    // Predicted parser output, one per result transfer.
    typedef struct packed {
        logic [7:0]  ch;
        logic        valid;
        field_kind_t kind;
        logic        fend;
        logic        len_hdr;
        logic        frame_done;
        err_code_t   err;
    } parse_res_t;

    localparam int HOLD_CYCLES = 300;   // length of the long receiver hold-off
    localparam int HOLD_AFTER  = 450;   // input transfers before the hold-off starts
    localparam int RAND_BYTES  = 450;   // random stream bytes to queue

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic [0:0]  s_axis_tuser = 1'b0;

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [4:0]  m_axis_tuser;

    stream_item_t pending[$];       // bytes still to be offered
    parse_res_t   expected[$];      // results predicted but not yet seen
    logic [7:0]   frame_buf[$];     // frame under construction

    string        cl_key_text = "content-length";

    // Predictor state, mirrors the parser's frame state.
    phase_t       pstate;
    bit           esc_armed;
    bit           line_open;
    int           match_pos;
    bit           key_off;
    bit           len_fixed;
    bit           len_counted;
    bit           len_seen_digit;
    logic [63:0]  len_value;
    logic [63:0]  body_left;

    int           gap_left = 0;
    bit           tx_calm = 1'b0;
    int           rx_stall = 0;
    bit           rx_calm = 1'b0;

    bit           hold_active = 1'b0;
    bit           hold_done = 1'b0;
    int           hold_cycles = 0;

    int           n_in = 0;
    int           n_queued = 0;
    int           n_results = 0;
    int           n_frames = 0;
    int           n_faults = 0;
    int           mismatch_cnt = 0;

    stomp_frame_parser_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    task automatic clear_parser_state();
        pstate         = PH_CMD;
        esc_armed      = 1'b0;
        line_open      = 1'b0;
        match_pos      = 0;
        key_off        = 1'b0;
        len_fixed      = 1'b0;
        len_counted    = 1'b0;
        len_seen_digit = 1'b0;
        len_value      = '0;
        body_left      = '0;
    endtask

    function automatic parse_res_t res(input logic [7:0] ch, input logic valid,
                                       input field_kind_t kind, input logic fend,
                                       input logic len_hdr, input logic frame_done,
                                       input err_code_t err);
        parse_res_t r;
        r.ch         = ch;
        r.valid      = valid;
        r.kind       = kind;
        r.fend       = fend;
        r.len_hdr    = len_hdr;
        r.frame_done = frame_done;
        r.err        = err;
        return r;
    endfunction

    // An error result; the parser then drops bytes until end of stream.
    function automatic parse_res_t fault(input err_code_t err);
        pstate = PH_ERR;
        return res(8'h00, 1'b0, KIND_CMD, 1'b0, 1'b0, 1'b0, err);
    endfunction

    // Resolve the byte after a backslash; returns 0 for an unknown escape.
    function automatic bit decode_escape(input logic [7:0] c, output logic [7:0] u);
        u = 8'h00;
        case (c)
            CH_N:      u = CH_LF;
            CH_R:      u = CH_CR;
            CH_BSLASH: u = CH_BSLASH;
            CH_C:      u = CH_COLON;
            default:   return 1'b0;
        endcase
        return 1'b1;
    endfunction

    // Advance the frame state by one stream transfer and give the result it causes.
    task automatic predict_byte(input logic [7:0] c, input logic eos,
                                output bit got, output parse_res_t r);
        logic [7:0]  u;
        logic [63:0] d;
        bit          is_cl;
        bit          flag;

        got = 1'b1;
        u   = c;
        r   = res(8'h00, 1'b0, KIND_CMD, 1'b0, 1'b0, 1'b0, ERR_NONE);

        if (eos)
        begin
            case (pstate)
                PH_CMD:              begin got = line_open; r.err = ERR_EOF_CMD; end
                PH_KEY, PH_VAL:      r.err = ERR_EOF_HDR;
                PH_BODY_LEN:         r.err = ERR_MISSING_DATA;
                PH_BODY_NUL:         r.err = ERR_MISSING_NUL;
                default:             got = 1'b0;
            endcase
            clear_parser_state();
            return;
        end

        case (pstate)
            PH_CMD:
            begin
                if (c == CH_LF)
                begin
                    pstate    = PH_KEY;
                    line_open = 1'b0;
                    r = res(8'h00, 1'b0, KIND_CMD, 1'b1, 1'b0, 1'b0, ERR_NONE);
                end
                else
                begin
                    line_open = 1'b1;
                    r = res(c, 1'b1, KIND_CMD, 1'b0, 1'b0, 1'b0, ERR_NONE);
                end
            end

            PH_KEY:
            begin
                if (c == CH_LF)
                begin
                    if (line_open)
                    begin
                        r = fault(ERR_MISSING_COLON);
                        return;
                    end
                    // empty line: headers are over, body mode is fixed now
                    pstate    = len_counted ? PH_BODY_LEN : PH_BODY_NUL;
                    body_left = len_value;
                    got       = 1'b0;
                    return;
                end
                line_open = 1'b1;
                if (c == CH_COLON)
                begin
                    if (esc_armed)
                    begin
                        r = fault(ERR_DANGLING_ESC);
                        return;
                    end
                    pstate = PH_VAL;
                    r = res(8'h00, 1'b0, KIND_KEY, 1'b1, 1'b0, 1'b0, ERR_NONE);
                    return;
                end
                if (esc_armed)
                begin
                    if (!decode_escape(c, u))
                    begin
                        r = fault(ERR_UNKNOWN_ESC);
                        return;
                    end
                    esc_armed = 1'b0;
                end
                else if (c == CH_BSLASH)
                begin
                    esc_armed = 1'b1;
                    got       = 1'b0;
                    return;
                end
                // track whether the unescaped key spells content-length
                if (!key_off && match_pos < cl_key_text.len() && u == cl_key_text[match_pos])
                    match_pos++;
                else
                    key_off = 1'b1;
                r = res(u, 1'b1, KIND_KEY, 1'b0, 1'b0, 1'b0, ERR_NONE);
            end

            PH_VAL:
            begin
                is_cl = !key_off && match_pos == cl_key_text.len();
                if (c == CH_LF)
                begin
                    if (esc_armed)
                    begin
                        r = fault(ERR_DANGLING_ESC);
                        return;
                    end
                    flag = 1'b0;
                    if (is_cl)
                    begin
                        // only the first content-length header decides the body mode
                        if (!len_fixed)
                        begin
                            len_fixed   = 1'b1;
                            len_counted = len_seen_digit;
                        end
                        flag = len_counted;
                    end
                    pstate    = PH_KEY;
                    line_open = 1'b0;
                    match_pos = 0;
                    key_off   = 1'b0;
                    r = res(8'h00, 1'b0, KIND_VAL, 1'b1, flag, 1'b0, ERR_NONE);
                    return;
                end
                if (esc_armed)
                begin
                    if (!decode_escape(c, u))
                    begin
                        r = fault(ERR_UNKNOWN_ESC);
                        return;
                    end
                    esc_armed = 1'b0;
                end
                else if (c == CH_BSLASH)
                begin
                    esc_armed = 1'b1;
                    got       = 1'b0;
                    return;
                end
                if (is_cl && !len_fixed)
                begin
                    if (u < CH_ZERO || u > CH_NINE)
                    begin
                        r = fault(ERR_BAD_LENGTH);
                        return;
                    end
                    d = 64'(u - CH_ZERO);
                    // reject a count that would pass 2^64-1
                    if (len_value > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10)
                    begin
                        r = fault(ERR_BAD_LENGTH);
                        return;
                    end
                    len_value      = len_value * 64'd10 + d;
                    len_seen_digit = 1'b1;
                end
                r = res(u, 1'b1, KIND_VAL, 1'b0, 1'b0, 1'b0, ERR_NONE);
            end

            PH_BODY_LEN:
            begin
                if (body_left != 0)
                begin
                    body_left--;
                    r = res(c, 1'b1, KIND_BODY, 1'b0, 1'b0, 1'b0, ERR_NONE);
                end
                else if (c != CH_NUL)
                    r = fault(ERR_MISSING_NUL);
                else
                begin
                    clear_parser_state();
                    r = res(8'h00, 1'b0, KIND_BODY, 1'b1, 1'b0, 1'b1, ERR_NONE);
                end
            end

            PH_BODY_NUL:
            begin
                if (c == CH_NUL)
                begin
                    clear_parser_state();
                    r = res(8'h00, 1'b0, KIND_BODY, 1'b1, 1'b0, 1'b1, ERR_NONE);
                end
                else
                    r = res(c, 1'b1, KIND_BODY, 1'b0, 1'b0, 1'b0, ERR_NONE);
            end

            default:
                got = 1'b0;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stream building
    // ------------------------------------------------------------------

    task automatic put(input logic [7:0] b);
        frame_buf = {frame_buf, b};
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put(s[i]);
    endtask

    // Move the frame buffer into the send queue.
    task automatic flush_frame();
        stream_item_t it;
        foreach (frame_buf[i])
        begin
            it.data  = frame_buf[i];
            it.eos   = 1'b0;
            it.pause = 1'b0;
            pending = {pending, it};
            n_queued++;
        end
        frame_buf.delete();
    endtask

    // Close the stream; the data byte rides along with a random value.
    task automatic send_eos();
        stream_item_t it;
        it.data  = 8'($urandom_range(0, 255));
        it.eos   = 1'b1;
        it.pause = 1'b0;
        pending = {pending, it};
        n_queued++;
    endtask

    task automatic send_pause();
        stream_item_t it;
        it.data  = 8'h00;
        it.eos   = 1'b0;
        it.pause = 1'b1;
        pending = {pending, it};
    endtask

    task automatic send_case(input string s, input bit close);
        put_text(s);
        flush_frame();
        if (close)
            send_eos();
    endtask

    function automatic logic [7:0] any_but(input logic [7:0] x);
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == x);
        return b;
    endfunction

    // Header text byte that needs no escape: mostly lower case, sometimes anything.
    function automatic logic [7:0] plain_char();
        logic [7:0] b;
        if ($urandom_range(0, 99) < 80)
            return 8'($urandom_range(8'h61, 8'h7A));
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_LF || b == CH_COLON || b == CH_BSLASH);
        return b;
    endfunction

    task automatic put_field(input int n, input bit is_value);
        int pick;
        repeat (n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
            begin
                put(CH_BSLASH);
                case ($urandom_range(0, 3))
                    0:       put(CH_N);
                    1:       put(CH_R);
                    2:       put(CH_BSLASH);
                    default: put(CH_C);
                endcase
            end
            else if (is_value && pick < 20)
                put(CH_COLON);
            else
                put(plain_char());
        end
    endtask

    // Build one well-formed frame, then send it whole, cut short, damaged or as noise.
    task automatic gen_frame();
        int  count;
        int  k;
        int  mode;
        bit  counted;
        bit  cl_seen;

        counted = 1'b0;
        cl_seen = 1'b0;
        count   = 0;
        frame_buf.delete();

        repeat ($urandom_range(0, 6))
            put(any_but(CH_LF));
        put(CH_LF);

        repeat ($urandom_range(0, 4))
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                put_text(cl_key_text);
                put(CH_COLON);
                if (!cl_seen)
                begin
                    cl_seen = 1'b1;
                    if ($urandom_range(0, 4) != 0)
                    begin
                        // keep bodies short, with an occasional long one
                        count = ($urandom_range(0, 29) == 0) ? $urandom_range(100, 300)
                                                             : $urandom_range(0, 24);
                        put_text($sformatf("%0d", count));
                        counted = 1'b1;
                    end
                end
                else
                    put_text($sformatf("%0d", $urandom_range(0, 99)));
            end
            else
            begin
                put_field($urandom_range(0, 6), 1'b0);
                put(CH_COLON);
                put_field($urandom_range(0, 8), 1'b1);
            end
            put(CH_LF);
        end
        put(CH_LF);

        if (counted)
            repeat (count)
                put(8'($urandom_range(0, 255)));
        else
            repeat ($urandom_range(0, 12))
                put(any_but(CH_NUL));
        put(CH_NUL);

        mode = $urandom_range(0, 99);
        if (mode < 75)
        begin
            flush_frame();
            if ($urandom_range(0, 4) == 0)
                send_eos();
        end
        else if (mode < 87)
        begin
            k = $urandom_range(0, frame_buf.size() - 1);
            while (frame_buf.size() > k)
                frame_buf.delete(frame_buf.size() - 1);
            flush_frame();
            send_eos();
        end
        else if (mode < 95)
        begin
            frame_buf[$urandom_range(0, frame_buf.size() - 1)] = 8'($urandom_range(0, 255));
            flush_frame();
            send_eos();
        end
        else
        begin
            frame_buf.delete();
            repeat ($urandom_range(1, 10))
                put(8'($urandom_range(0, 255)));
            flush_frame();
            send_eos();
        end
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string field, input logic [15:0] want,
                                   input logic [15:0] seen);
        $display("mismatch in %s on result %0d: expected %0h, got %0h",
                 field, n_results, want, seen);
        mismatch_cnt++;
    endtask

    // ------------------------------------------------------------------
    // Sender: offer queued bytes, predict each accepted transfer
    // ------------------------------------------------------------------

    function automatic int pick_gap();
        int pick;
        if (tx_calm)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 85)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    always @(posedge clk)
    begin
        bit           offer;
        bit           got;
        parse_res_t   r;
        stream_item_t it;

        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
            s_axis_tuser  <= 1'b0;
        end
        else
        begin
            offer = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_byte(s_axis_tdata, s_axis_tuser[0], got, r);
                if (got)
                    expected = {expected, r};
                n_in  <= n_in + 1;
                offer = 1'b0;
                if ($urandom_range(0, 149) == 0)
                    tx_calm = !tx_calm;
                gap_left = pick_gap();
            end
            if (!offer)
            begin
                // during the long hold-off keep offering, so the parser backs up
                if (gap_left > 0 && !hold_active)
                    gap_left--;
                else if (pending.size() > 0)
                begin
                    if (pending[0].pause)
                    begin
                        if (expected.size() == 0)
                            void'(pending.pop_front());
                    end
                    else
                    begin
                        it = pending.pop_front();
                        s_axis_tdata <= it.data;
                        s_axis_tuser <= it.eos;
                        offer = 1'b1;
                    end
                end
            end
            s_axis_tvalid <= offer;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: check each result transfer, stall at random
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        parse_res_t want;

        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected.size() == 0)
                    report_mismatch("unexpected result tdata", 16'h0, m_axis_tdata);
                else
                begin
                    want = expected.pop_front();
                    if (m_axis_tdata[7:0] !== want.ch)
                        report_mismatch("out_byte", 16'(want.ch), 16'(m_axis_tdata[7:0]));
                    if (m_axis_tdata[11:8] !== want.err)
                        report_mismatch("error_code", 16'(want.err), 16'(m_axis_tdata[11:8]));
                    if (m_axis_tdata[15:12] !== 4'h0)
                        report_mismatch("tdata pad", 16'h0, 16'(m_axis_tdata[15:12]));
                    if (m_axis_tuser[0] !== want.valid)
                        report_mismatch("byte_valid", 16'(want.valid), 16'(m_axis_tuser[0]));
                    if (m_axis_tuser[2:1] !== want.kind)
                        report_mismatch("field_kind", 16'(want.kind), 16'(m_axis_tuser[2:1]));
                    if (m_axis_tlast !== want.fend)
                        report_mismatch("field_end", 16'(want.fend), 16'(m_axis_tlast));
                    if (m_axis_tuser[3] !== want.len_hdr)
                        report_mismatch("length_header", 16'(want.len_hdr),
                                        16'(m_axis_tuser[3]));
                    if (m_axis_tuser[4] !== want.frame_done)
                        report_mismatch("frame_end", 16'(want.frame_done),
                                        16'(m_axis_tuser[4]));
                    if (want.frame_done)
                        n_frames++;
                    if (want.err != ERR_NONE)
                        n_faults++;
                end
                n_results++;
            end

            if (hold_active)
                m_axis_tready <= 1'b0;
            else if (rx_stall > 0)
            begin
                rx_stall--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                if ($urandom_range(0, 199) == 0)
                    rx_calm = !rx_calm;
                if (!rx_calm && $urandom_range(0, 99) < 25)
                begin
                    rx_stall = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                          : $urandom_range(0, 2);
                    m_axis_tready <= 1'b0;
                end
                else
                    m_axis_tready <= 1'b1;
            end
        end
    end

    // One long receiver hold-off, counted here, once enough traffic has passed.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_active)
            begin
                if (hold_cycles == HOLD_CYCLES - 1)
                    hold_active <= 1'b0;
                hold_cycles <= hold_cycles + 1;
            end
            else if (!hold_done && n_in >= HOLD_AFTER)
            begin
                hold_active <= 1'b1;
                hold_done   <= 1'b1;
                hold_cycles <= 0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------

    initial
    begin
        bit paused;

        clear_parser_state();

        // end of stream with nothing sent is silent
        send_eos();
        // end of stream in the command, and in a header
        send_case("X", 1'b1);
        send_case("C\nk", 1'b1);
        // newline inside a key, then a byte dropped in the error phase
        send_case("C\nkey\n", 1'b0);
        put(8'hFF);
        flush_frame();
        send_eos();
        // newline right after a backslash in a key
        send_case("C\nk\\\n", 1'b1);
        // escaped colon in a key, unknown escape in a key
        send_case("C\n\\:", 1'b1);
        send_case("C\n\\q", 1'b1);
        // escaped colon in a value, newline after a backslash in a value
        send_case("C\nk:\\:", 1'b1);
        send_case("C\nk:\\\n", 1'b1);
        // full frame: extreme command bytes, every escape, literal colons in a value
        put(8'h00);
        put(8'hFF);
        put_text("\nk\\n\\r\\\\\\c:v:w\\c\n\nbody");
        put(8'h80);
        put(8'h7F);
        put(CH_NUL);
        flush_frame();
        // counted body carrying NUL and newline; the later length header is flagged too
        put_text("M\ncontent-length:3\ncontent-length:9\n\n");
        put(8'h00);
        put(8'hFF);
        put(CH_LF);
        put(CH_NUL);
        flush_frame();
        // empty first length value: body runs to NUL, later header not flagged
        put_text("M\ncontent-length:\ncontent-length:5\n\nab");
        put(CH_NUL);
        flush_frame();
        send_eos();
        // length faults: non-digit, and one past the largest count
        send_case("M\ncontent-length:1x", 1'b1);
        send_case("M\ncontent-length:18446744073709551616", 1'b1);
        // largest count accepted, stream closes inside the body
        send_case("M\ncontent-length:18446744073709551615\n\nab", 1'b1);
        // counted body not followed by NUL, then a silent close in the error phase
        send_case("M\ncontent-length:1\n\nab", 1'b1);
        // stream closes while the NUL of a counted body is awaited
        send_case("M\ncontent-length:0\n\n", 1'b1);
        // stream closes in an uncounted body
        send_case("M\n\nxy", 1'b1);
        send_pause();

        n_queued = 0;
        paused   = 1'b0;
        while (n_queued < RAND_BYTES)
        begin
            gen_frame();
            if (!paused && n_queued > RAND_BYTES / 2)
            begin
                send_pause();
                paused = 1'b1;
            end
        end
        send_eos();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // drain: everything offered, everything predicted has come back
        @(negedge clk);
        while (pending.size() != 0 || s_axis_tvalid || expected.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        $display("run covered %0d input transfers and %0d results: %0d frames closed,",
                 n_in, n_results, n_frames);
        $display("%0d parser errors raised, one long output hold-off", n_faults);
        if (mismatch_cnt == 0 && expected.size() == 0)
            $display("stomp_frame_parser_top_test: clean");
        else
            $display("stomp_frame_parser_top_test: errors");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout with %0d results still expected", expected.size());
        $display("stomp_frame_parser_top_test: errors");
        $finish;
    end

endmodule

@@ stomp_frame_parser_top.f @@
+incdir+sv
sv/stfp_pkg.sv
sv/stfp_in_reg.sv
sv/stfp_parser.sv
sv/stomp_frame_parser_top.sv
dv/stomp_frame_parser_top_test.sv
